// ===== hdl/swpwd_pkg.sv =====
// shared types and constants of the single-wire pulse width decoder
// no dependencies; compiled before the interfaces and the core
package swpwd_pkg;

    // operation codes of an input request
    localparam logic OP_START = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    // line level after an edge
    localparam logic LEVEL_FALL = 1'b0;
    localparam logic LEVEL_RISE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_BIT_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SKIP_PULSES   = 2'd1;
    localparam logic [1:0] REG_VALID_LIMIT   = 2'd2;

    // configuration reset values
    localparam logic [7:0]  RST_BIT_THRESHOLD = 8'd55;
    localparam logic [2:0]  RST_SKIP_PULSES   = 3'd2;
    localparam logic [15:0] RST_VALID_LIMIT   = 16'd999;

    // saturation value of a measured pulse width
    localparam logic [7:0] WIDTH_MAX = 8'd255;

    // field widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int TIME_W      = 32;
    localparam int OUT_INDEX_W = 2;
    localparam int OUT_VALUE_W = 16;

endpackage

// ===== hdl/swpwd_if.sv =====
// request channels of the single-wire pulse width decoder: edge input,
// word output and configuration write
// depends on swpwd_pkg for the field widths

// edge event channel
interface swpwd_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic                             line_level;
    logic [swpwd_pkg::TIME_W-1:0]     time_us;

    modport source (output valid, operation, line_level, time_us, input ready);
    modport sink   (input valid, operation, line_level, time_us, output ready);
endinterface

// decoded word channel
interface swpwd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [swpwd_pkg::OUT_INDEX_W-1:0]    word_index;
    logic [swpwd_pkg::OUT_VALUE_W-1:0]    word_value;
    logic                                 in_range;
    logic                                 last;

    modport source (output valid, word_index, word_value, in_range, last, input ready);
    modport sink   (input valid, word_index, word_value, in_range, last, output ready);
endinterface

// configuration write channel
interface swpwd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [swpwd_pkg::CFG_INDEX_W-1:0]    index;
    logic [swpwd_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/single_wire_pulse_width_decoder_core.sv =====
// single-wire pulse width decoder: turns timestamped line edges into data words
// depends on swpwd_pkg and the channel interfaces in swpwd_if.sv
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------
//  i_in     | in        | operation, line_level, time_us
//  o_out    | out       | word_index, word_value, in_range, last
//  i_cfg    | in        | index, data (bit_threshold, skip_pulses, valid_limit)
//
// one edge request per cycle while the output register is empty or taken; a
// request is captured in an input register and decoded from there into the
// frame state and the output register. a full output register that is not
// taken holds the decode stage and then the input register. synchronous
// active-low reset clears the frame state and loads the register defaults.
// configuration writes are always taken.
module single_wire_pulse_width_decoder_core #(
    parameter int FRAME_PULSES = 45,
    parameter int WORD_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    swpwd_in_if.sink           i_in,
    swpwd_out_if.source        o_out,
    swpwd_cfg_if.sink          i_cfg
);

    localparam int PC_W  = $clog2(FRAME_PULSES + 1);
    localparam int BP_W  = $clog2(WORD_BITS);
    localparam int CMP_W = (PC_W > 3) ? PC_W : 3;
    localparam int TW    = swpwd_pkg::TIME_W;

    localparam logic [PC_W-1:0] LAST_PULSE = PC_W'(FRAME_PULSES);
    localparam logic [BP_W-1:0] TOP_BIT    = BP_W'(WORD_BITS - 1);

    // configuration registers
    logic [7:0]  r_bit_threshold;
    logic [2:0]  r_skip_pulses;
    logic [15:0] r_valid_limit;

    // input register
    logic          r_in_valid;
    logic          r_in_op;
    logic          r_in_level;
    logic [TW-1:0] r_in_time;

    // frame state
    logic [TW-1:0]        r_rise_time,    n_rise_time;
    logic                 r_rise_seen,    n_rise_seen;
    logic [PC_W-1:0]      r_pulse_count,  n_pulse_count;
    logic [WORD_BITS-1:0] r_shift_word,   n_shift_word;
    logic [BP_W-1:0]      r_bit_position, n_bit_position;
    logic [1:0]           r_word_count,   n_word_count;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_index,  n_out_index;
    logic [15:0] r_out_value,  n_out_value;
    logic        r_out_range,  n_out_range;
    logic        r_out_last,   n_out_last;
    logic        n_emit;

    logic          advance;
    logic          process;
    logic          in_take;
    logic [TW-1:0] width_full;
    logic [7:0]    width_sat;
    logic [WORD_BITS-1:0] word_set;
    logic [31:0]   word_ext;
    logic          frame_end;

    // handshakes
    assign advance     = !r_out_valid || o_out.ready;
    assign process     = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;
    assign in_take     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_threshold <= swpwd_pkg::RST_BIT_THRESHOLD;
            r_skip_pulses   <= swpwd_pkg::RST_SKIP_PULSES;
            r_valid_limit   <= swpwd_pkg::RST_VALID_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                swpwd_pkg::REG_BIT_THRESHOLD: r_bit_threshold <= i_cfg.data[7:0];
                swpwd_pkg::REG_SKIP_PULSES:   r_skip_pulses   <= i_cfg.data[2:0];
                swpwd_pkg::REG_VALID_LIMIT:   r_valid_limit   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op    <= i_in.operation;
            r_in_level <= i_in.line_level;
            r_in_time  <= i_in.time_us;
        end
    end

    // pulse width, saturated, and the word with the new bit set
    assign width_full = r_in_time - r_rise_time;
    assign width_sat  = (|width_full[TW-1:8]) ? swpwd_pkg::WIDTH_MAX : width_full[7:0];
    assign word_set   = r_shift_word
                      | (WORD_BITS'(width_sat >= r_bit_threshold) << r_bit_position);
    assign word_ext   = 32'(word_set);
    assign frame_end  = (r_pulse_count + PC_W'(1)) == LAST_PULSE;

    // decode step
    always_comb begin
        n_rise_time    = r_rise_time;
        n_rise_seen    = r_rise_seen;
        n_pulse_count  = r_pulse_count;
        n_shift_word   = r_shift_word;
        n_bit_position = r_bit_position;
        n_word_count   = r_word_count;
        n_emit         = 1'b0;
        n_out_index    = r_word_count;
        n_out_value    = word_ext[15:0];
        n_out_range    = word_ext < 32'(r_valid_limit);
        n_out_last     = 1'b0;

        if (r_in_op == swpwd_pkg::OP_START) begin
            // start of a new frame
            n_rise_time    = '0;
            n_rise_seen    = 1'b0;
            n_pulse_count  = '0;
            n_shift_word   = '0;
            n_bit_position = TOP_BIT;
            n_word_count   = '0;
        end else if (r_in_level == swpwd_pkg::LEVEL_RISE) begin
            n_rise_time = r_in_time;
            n_rise_seen = 1'b1;
        end else if (r_rise_seen && r_pulse_count < LAST_PULSE) begin
            n_pulse_count = r_pulse_count + PC_W'(1);
            // leading pulses give no bit
            if (CMP_W'(r_pulse_count) >= CMP_W'(r_skip_pulses)) begin
                n_shift_word = word_set;
                if (r_bit_position == '0) begin
                    n_emit     = 1'b1;
                    n_out_last = frame_end;
                end else begin
                    n_bit_position = r_bit_position - BP_W'(1);
                    if (frame_end) begin
                        n_emit     = 1'b1;
                        n_out_last = 1'b1;
                    end
                end
                if (n_emit) begin
                    n_word_count   = r_word_count + 2'd1;
                    n_shift_word   = '0;
                    n_bit_position = TOP_BIT;
                end
            end
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_time    <= '0;
            r_rise_seen    <= 1'b0;
            r_pulse_count  <= '0;
            r_shift_word   <= '0;
            r_bit_position <= TOP_BIT;
            r_word_count   <= '0;
        end else if (process) begin
            r_rise_time    <= n_rise_time;
            r_rise_seen    <= n_rise_seen;
            r_pulse_count  <= n_pulse_count;
            r_shift_word   <= n_shift_word;
            r_bit_position <= n_bit_position;
            r_word_count   <= n_word_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= process && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && n_emit) begin
            r_out_index <= n_out_index;
            r_out_value <= n_out_value;
            r_out_range <= n_out_range;
            r_out_last  <= n_out_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.word_index = r_out_index;
    assign o_out.word_value = r_out_value;
    assign o_out.in_range   = r_out_range;
    assign o_out.last       = r_out_last;

endmodule
